// File: rtl/bsa_pkg.sv
// ----------------------------------------------------------------------------
// bsa_pkg
// Shared types, codes and defaults of the banker's safety allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package bsa_pkg;

    // default sizes
    localparam int MAX_PROCESSES_DEF = 8;
    localparam int MAX_RESOURCES_DEF = 4;
    localparam int COUNT_WIDTH_DEF   = 8;

    // input modes
    localparam logic [1:0] MODE_SET_TOTAL = 2'd0;
    localparam logic [1:0] MODE_LOAD      = 2'd1;
    localparam logic [1:0] MODE_SAFETY    = 2'd2;
    localparam logic [1:0] MODE_REQUEST   = 2'd3;

    // result status codes
    localparam logic [2:0] ST_ACCEPTED    = 3'd0;
    localparam logic [2:0] ST_SAFE_ENTRY  = 3'd1;
    localparam logic [2:0] ST_UNSAFE      = 3'd2;
    localparam logic [2:0] ST_OVER_NEED   = 3'd3;
    localparam logic [2:0] ST_OVER_AVAIL  = 3'd4;
    localparam logic [2:0] ST_LOAD_REJECT = 3'd5;

    // configuration registers, selected by paddr[2]
    localparam logic REG_NUM_RES  = 1'b0;
    localparam logic REG_NUM_PROC = 1'b1;

    localparam logic [2:0] NUM_RES_RESET  = 3'd4;
    localparam logic [3:0] NUM_PROC_RESET = 4'd8;

    typedef struct packed {
        logic [1:0] mode;
        logic [2:0] process_id;
        logic [1:0] resource_id;
        logic [7:0] amount;
        logic [7:0] max_claim;
        logic       last_element;
    } t_in_item;

    typedef struct packed {
        logic [2:0] status;
        logic [2:0] process_index;
        logic       last_result;
    } t_out_item;

    // controller to datapath
    typedef struct packed {
        logic capture;
        logic decode;
        logic recalc;
        logic check;
        logic scan_init;
        logic scan_step;
        logic rollback;
        logic emit;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic [1:0] mode;
        logic       last;
        logic       rid_ok;
        logic       load_ok;
        logic       recalc_last;
        logic       check_fail;
        logic       scan_done;
        logic       scan_safe;
        logic       out_free;
        logic       emit_last;
    } t_sts;

endpackage

`default_nettype wire

// File: rtl/bsa_ctrl.sv
// ----------------------------------------------------------------------------
// bsa_ctrl
// Sequencer: decode, recompute, check, grant, scan, rollback and emit.
// ----------------------------------------------------------------------------
`default_nettype none

module bsa_ctrl (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_in_valid,
    output logic              o_in_stall,
    input  wire bsa_pkg::t_sts i_sts,
    output bsa_pkg::t_cmd     o_cmd
);
    import bsa_pkg::*;

    typedef enum logic [7:0] {
        S_IDLE     = 8'b0000_0001,
        S_DECODE   = 8'b0000_0010,
        S_RECALC   = 8'b0000_0100,
        S_CHECK    = 8'b0000_1000,
        S_SINIT    = 8'b0001_0000,
        S_SCAN     = 8'b0010_0000,
        S_ROLLBACK = 8'b0100_0000,
        S_EMIT     = 8'b1000_0000
    } t_state;

    t_state r_state, n_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                o_cmd.capture = i_in_valid;
                if (i_in_valid) n_state = S_DECODE;
            end
            S_DECODE: begin
                o_cmd.decode = 1'b1;
                case (i_sts.mode)
                    MODE_SET_TOTAL: n_state = i_sts.rid_ok ? S_RECALC : S_EMIT;
                    MODE_LOAD:      n_state = i_sts.load_ok ? S_RECALC : S_EMIT;
                    MODE_SAFETY:    n_state = S_SINIT;
                    default:        n_state = i_sts.last ? S_CHECK : S_EMIT;
                endcase
            end
            S_RECALC: begin
                o_cmd.recalc = 1'b1;
                if (i_sts.recalc_last) n_state = S_EMIT;
            end
            S_CHECK: begin
                o_cmd.check = 1'b1;
                n_state = i_sts.check_fail ? S_EMIT : S_SINIT;
            end
            S_SINIT: begin
                o_cmd.scan_init = 1'b1;
                n_state = S_SCAN;
            end
            S_SCAN: begin
                o_cmd.scan_step = 1'b1;
                if (i_sts.scan_done) begin
                    if (i_sts.mode == MODE_REQUEST && !i_sts.scan_safe) n_state = S_ROLLBACK;
                    else n_state = S_EMIT;
                end
            end
            S_ROLLBACK: begin
                o_cmd.rollback = 1'b1;
                n_state = S_EMIT;
            end
            S_EMIT: begin
                if (i_sts.out_free) begin
                    o_cmd.emit = 1'b1;
                    if (i_sts.emit_last) n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign o_in_stall = (r_state != S_IDLE);

endmodule

`default_nettype wire

// File: rtl/bsa_datapath.sv
// ----------------------------------------------------------------------------
// bsa_datapath
// Tables, request buffer, scan counters and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module bsa_datapath #(
    parameter int MAX_PROCESSES = bsa_pkg::MAX_PROCESSES_DEF,
    parameter int MAX_RESOURCES = bsa_pkg::MAX_RESOURCES_DEF,
    parameter int COUNT_WIDTH   = bsa_pkg::COUNT_WIDTH_DEF
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire bsa_pkg::t_cmd     i_cmd,
    output bsa_pkg::t_sts          o_sts,
    input  wire bsa_pkg::t_in_item i_in_item,
    input  wire logic [2:0]        i_num_res,
    input  wire logic [3:0]        i_num_proc,
    output logic                   o_out_valid,
    input  wire logic              i_out_stall,
    output bsa_pkg::t_out_item     o_out_item
);
    import bsa_pkg::*;

    localparam int PW  = (MAX_PROCESSES > 1) ? $clog2(MAX_PROCESSES) : 1;
    localparam int KW  = $clog2(MAX_PROCESSES + 1);
    localparam int RW  = (MAX_RESOURCES > 1) ? $clog2(MAX_RESOURCES) : 1;
    localparam int RCW = $clog2(MAX_RESOURCES + 1);
    localparam int CW  = COUNT_WIDTH;
    localparam int WW  = CW + 1;
    localparam int SW  = CW + PW + 1;

    t_in_item            r_item;
    logic [CW-1:0]       r_total [MAX_RESOURCES];
    logic [CW-1:0]       r_avail [MAX_RESOURCES];
    logic [CW-1:0]       r_alloc [MAX_PROCESSES][MAX_RESOURCES];
    logic [CW-1:0]       r_need  [MAX_PROCESSES][MAX_RESOURCES];
    logic [CW-1:0]       r_req   [MAX_RESOURCES];
    logic [WW-1:0]       r_work  [MAX_RESOURCES];
    logic [SW-1:0]       r_sum   [MAX_RESOURCES];
    logic [PW-1:0]       r_seq   [MAX_PROCESSES];
    logic [MAX_PROCESSES-1:0] r_fin;
    logic [PW-1:0]       r_p, r_e, r_row;
    logic [KW-1:0]       r_k;
    logic                r_seq_mode;
    logic [2:0]          r_rstat;
    logic                r_ovalid;
    t_out_item           r_oitem;

    logic [RCW-1:0]      nr_eff;
    logic [KW-1:0]       np_eff;
    logic [MAX_RESOURCES-1:0] lane;
    logic                pid_ok, rid_ok, load_ok;
    logic [PW-1:0]       pidx;
    logic [RW-1:0]       ridx;
    logic [CW-1:0]       amt, clm;
    logic                chk_fail, chk_found;
    logic [2:0]          chk_status;
    logic                fits, scan_done, scan_safe, recalc_last, emit_last, out_free;

    // clamp configuration and decode captured item
    always_comb begin
        if (i_num_res == 3'd0) nr_eff = RCW'(1);
        else if (4'(i_num_res) > 4'(MAX_RESOURCES)) nr_eff = RCW'(MAX_RESOURCES);
        else nr_eff = RCW'(i_num_res);
        if (i_num_proc == 4'd0) np_eff = KW'(1);
        else if (7'(i_num_proc) > 7'(MAX_PROCESSES)) np_eff = KW'(MAX_PROCESSES);
        else np_eff = KW'(i_num_proc);
        for (int r = 0; r < MAX_RESOURCES; r++) lane[r] = (8'(r) < 8'(nr_eff));
    end

    assign pid_ok  = 7'(r_item.process_id) < 7'(np_eff);
    assign rid_ok  = 8'(r_item.resource_id) < 8'(nr_eff);
    assign pidx    = PW'(r_item.process_id);
    assign ridx    = RW'(r_item.resource_id);
    assign amt     = CW'(r_item.amount);
    assign clm     = CW'(r_item.max_claim);
    assign load_ok = rid_ok && pid_ok && !(clm > r_total[ridx]) && !(amt > clm);

    // request check, first failing resource wins
    always_comb begin
        chk_found  = !pid_ok;
        chk_status = ST_OVER_NEED;
        for (int r = 0; r < MAX_RESOURCES; r++) begin
            if (!chk_found && lane[r]) begin
                if (r_req[r] > r_need[pidx][r]) begin
                    chk_found  = 1'b1;
                    chk_status = ST_OVER_NEED;
                end else if (r_req[r] > r_avail[r]) begin
                    chk_found  = 1'b1;
                    chk_status = ST_OVER_AVAIL;
                end
            end
        end
        chk_fail = chk_found;
    end

    // does process r_p fit in work
    always_comb begin
        fits = !r_fin[r_p];
        for (int r = 0; r < MAX_RESOURCES; r++) begin
            if (lane[r] && (WW'(r_need[r_p][r]) > r_work[r])) fits = 1'b0;
        end
    end

    assign scan_done   = !fits && (7'(r_p) == 7'(np_eff) - 7'd1);
    assign scan_safe   = (7'(r_k) == 7'(np_eff));
    assign recalc_last = (r_row == PW'(MAX_PROCESSES - 1));
    assign emit_last   = !r_seq_mode || (7'(r_e) == 7'(np_eff) - 7'd1);
    assign out_free    = !r_ovalid || !i_out_stall;

    always_comb begin
        o_sts.mode        = r_item.mode;
        o_sts.last        = r_item.last_element;
        o_sts.rid_ok      = rid_ok;
        o_sts.load_ok     = load_ok;
        o_sts.recalc_last = recalc_last;
        o_sts.check_fail  = chk_fail;
        o_sts.scan_done   = scan_done;
        o_sts.scan_safe   = scan_safe;
        o_sts.out_free    = out_free;
        o_sts.emit_last   = emit_last;
    end

    // tables, counters and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int r = 0; r < MAX_RESOURCES; r++) begin
                r_total[r] <= '0;
                r_avail[r] <= '0;
                r_req[r]   <= '0;
                for (int p = 0; p < MAX_PROCESSES; p++) begin
                    r_alloc[p][r] <= '0;
                    r_need[p][r]  <= '0;
                end
            end
            r_fin    <= '0;
            r_p      <= '0;
            r_k      <= '0;
            r_e      <= '0;
            r_row    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            // decode: table writes and request buffering
            if (i_cmd.decode) begin
                r_e   <= '0;
                r_row <= '0;
                case (r_item.mode)
                    MODE_SET_TOTAL: if (rid_ok) r_total[ridx] <= amt;
                    MODE_LOAD: begin
                        if (load_ok) begin
                            r_alloc[pidx][ridx] <= amt;
                            r_need[pidx][ridx]  <= clm - amt;
                        end
                    end
                    MODE_REQUEST: if (rid_ok) r_req[ridx] <= amt;
                    default: ;
                endcase
            end
            // availability from totals minus allocation, one row a cycle
            if (i_cmd.recalc) begin
                for (int r = 0; r < MAX_RESOURCES; r++) begin
                    if (recalc_last) begin
                        if ((r_sum[r] + SW'(r_alloc[r_row][r])) >= SW'(r_total[r]))
                            r_avail[r] <= '0;
                        else
                            r_avail[r] <= CW'(SW'(r_total[r]) - r_sum[r]
                                              - SW'(r_alloc[r_row][r]));
                    end
                end
                if (!recalc_last) r_row <= r_row + PW'(1);
            end
            // trial grant
            if (i_cmd.check && !chk_fail) begin
                for (int r = 0; r < MAX_RESOURCES; r++) begin
                    if (lane[r]) begin
                        r_avail[r]       <= r_avail[r] - r_req[r];
                        r_alloc[pidx][r] <= r_alloc[pidx][r] + r_req[r];
                        r_need[pidx][r]  <= r_need[pidx][r] - r_req[r];
                    end
                end
            end
            if (i_cmd.scan_init) begin
                r_fin <= '0;
                r_k   <= '0;
                r_p   <= '0;
            end
            // one process row per cycle, restart after each finish
            if (i_cmd.scan_step) begin
                if (fits) begin
                    r_fin[r_p] <= 1'b1;
                    r_k        <= r_k + KW'(1);
                    r_p        <= '0;
                end else if (!scan_done) begin
                    r_p <= r_p + PW'(1);
                end
            end
            if (i_cmd.rollback) begin
                for (int r = 0; r < MAX_RESOURCES; r++) begin
                    if (lane[r]) begin
                        r_avail[r]       <= r_avail[r] + r_req[r];
                        r_alloc[pidx][r] <= r_alloc[pidx][r] - r_req[r];
                        r_need[pidx][r]  <= r_need[pidx][r] + r_req[r];
                    end
                end
            end
            // output register
            if (i_cmd.emit) begin
                r_ovalid <= 1'b1;
                if (!emit_last) r_e <= r_e + PW'(1);
                if (emit_last && r_item.mode == MODE_REQUEST && r_item.last_element) begin
                    for (int r = 0; r < MAX_RESOURCES; r++) r_req[r] <= '0;
                end
            end else if (!i_out_stall) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) r_item <= i_in_item;
        if (i_cmd.decode) begin
            r_seq_mode <= 1'b0;
            for (int r = 0; r < MAX_RESOURCES; r++) r_sum[r] <= '0;
            case (r_item.mode)
                MODE_SET_TOTAL: r_rstat <= rid_ok ? ST_ACCEPTED : ST_LOAD_REJECT;
                MODE_LOAD:      r_rstat <= load_ok ? ST_ACCEPTED : ST_LOAD_REJECT;
                default:        r_rstat <= ST_ACCEPTED;
            endcase
        end
        if (i_cmd.recalc) begin
            for (int r = 0; r < MAX_RESOURCES; r++)
                r_sum[r] <= r_sum[r] + SW'(r_alloc[r_row][r]);
        end
        if (i_cmd.check && chk_fail) r_rstat <= chk_status;
        if (i_cmd.scan_init) begin
            for (int r = 0; r < MAX_RESOURCES; r++) r_work[r] <= WW'(r_avail[r]);
        end
        if (i_cmd.scan_step) begin
            if (fits) begin
                r_seq[r_k[PW-1:0]] <= r_p;
                for (int r = 0; r < MAX_RESOURCES; r++) begin
                    if (lane[r]) begin
                        if ((WW+1)'(r_work[r]) + (WW+1)'(r_alloc[r_p][r])
                                > (WW+1)'({WW{1'b1}}))
                            r_work[r] <= {WW{1'b1}};
                        else
                            r_work[r] <= r_work[r] + WW'(r_alloc[r_p][r]);
                    end
                end
            end else if (scan_done) begin
                r_seq_mode <= scan_safe;
                r_rstat    <= ST_UNSAFE;
            end
        end
        if (i_cmd.emit) begin
            r_oitem.status        <= r_seq_mode ? ST_SAFE_ENTRY : r_rstat;
            r_oitem.process_index <= r_seq_mode ? 3'(r_seq[r_e]) : 3'd0;
            r_oitem.last_result   <= emit_last;
        end
    end

    assign o_out_valid = r_ovalid;
    assign o_out_item  = r_oitem;

    // every finished process has one entry in the sequence
    a_fin_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(r_fin) == int'(r_k))
        else $error("finished flags disagree with sequence length");

    // sequence never longer than processes in use
    a_k_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.scan_step |-> (7'(r_k) < 7'(np_eff)) || !fits)
        else $error("scan picked more processes than in use");

    // a result is only written into a free output slot
    a_emit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.emit |-> out_free)
        else $error("result overwrote a pending item");

endmodule

`default_nettype wire

// File: rtl/bankers_safety_allocator_core.sv
// ----------------------------------------------------------------------------
// bankers_safety_allocator_core
// Banker's algorithm allocator: totals, claims, requests and safety scan.
//
//   channel  direction  handshake              payload
//   in       input      i_in_valid/o_in_stall  i_in_item  (t_in_item)
//   out      output     o_out_valid/i_out_stall o_out_item (t_out_item)
//   config   input      APB psel/penable       paddr/pwdata/prdata
//
// One item at a time. An accepted set total or load runs the row-at-a-time
// availability recompute. Safety check, and a last request element that
// passes its check, run the scan that tests one process row per cycle and
// restarts after each finish; results are then emitted. Synchronous
// active-low reset clears all tables; no clearing pass. A stalled output
// holds the block in emit.
// ----------------------------------------------------------------------------
`default_nettype none

module bankers_safety_allocator_core #(
    parameter int MAX_PROCESSES = bsa_pkg::MAX_PROCESSES_DEF,
    parameter int MAX_RESOURCES = bsa_pkg::MAX_RESOURCES_DEF,
    parameter int COUNT_WIDTH   = bsa_pkg::COUNT_WIDTH_DEF
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_stall,
    input  wire bsa_pkg::t_in_item i_in_item,
    output logic                   o_out_valid,
    input  wire logic              i_out_stall,
    output bsa_pkg::t_out_item     o_out_item,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [2:0]        paddr,
    input  wire logic [31:0]       pwdata,
    output logic [31:0]            prdata,
    output logic                   pready
);
    import bsa_pkg::*;

    logic [2:0] r_num_res;
    logic [3:0] r_num_proc;
    t_cmd       cmd;
    t_sts       sts;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_res  <= NUM_RES_RESET;
            r_num_proc <= NUM_PROC_RESET;
        end else if (psel && penable && pwrite) begin
            if (paddr[2] == REG_NUM_RES) r_num_res <= pwdata[2:0];
            else r_num_proc <= pwdata[3:0];
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_NUM_PROC) ? {28'd0, r_num_proc} : {29'd0, r_num_res};

    bsa_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    bsa_datapath #(
        .MAX_PROCESSES (MAX_PROCESSES),
        .MAX_RESOURCES (MAX_RESOURCES),
        .COUNT_WIDTH   (COUNT_WIDTH)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_in_item   (i_in_item),
        .i_num_res   (r_num_res),
        .i_num_proc  (r_num_proc),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item)
    );

endmodule

`default_nettype wire
